/* design/grid_cross_clearance_check_assert.svh */
// Assertion helpers for the clearance checker. Both sample on clk_i and
// stay quiet while rst_ni is low.
`ifndef GRID_CROSS_CLEARANCE_CHECK_ASSERT_SVH
`define GRID_CROSS_CLEARANCE_CHECK_ASSERT_SVH

// Same-cycle implication.
`define GCCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid cross clearance check: assertion failed");

// Next-cycle implication.
`define GCCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid cross clearance check: assertion failed");

`endif

/* design/gccc_pkg.sv */
package gccc_pkg;

  localparam int MAP_SIDE_DEF = 1024;
  localparam int ROW_W        = 10;
  localparam int RAD_W        = 6;
  localparam int VAL_W        = 8;

  localparam logic [RAD_W-1:0]        RADIUS_RESET = 6'd25;
  localparam logic signed [VAL_W-1:0] OCC_UNKNOWN  = -8'sd1;
  localparam logic signed [VAL_W-1:0] OCC_FULL     = 8'sd100;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ARM_UP,
    ARM_DOWN,
    ARM_RIGHT,
    ARM_LEFT
  } arm_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic probe;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_probe;
    logic rsp_free;
  } ctrl_sts_t;

endpackage

/* design/gccc_chan_if.sv */
interface gccc_req_if import gccc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ROW_W-1:0]          row;
  logic [ROW_W-1:0]          col;
  logic signed [VAL_W-1:0]   cell_value;

  modport source (output valid, output action, output row, output col,
                  output cell_value, input ready);
  modport sink (input valid, input action, input row, input col,
                input cell_value, output ready);
endinterface

interface gccc_rsp_if import gccc_pkg::*; ();
  logic valid;
  logic ready;
  logic clear;
  logic out_of_range;

  modport source (output valid, output clear, output out_of_range, input ready);
  modport sink (input valid, input clear, input out_of_range, output ready);
endinterface

interface gccc_cfg_if import gccc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] clear_radius;

  modport source (output valid, output clear_radius, input ready);
  modport sink (input valid, input clear_radius, output ready);
endinterface

/* design/gccc_ram.sv */
module gccc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* design/gccc_ctrl.sv */
module gccc_ctrl import gccc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_action_i,
  input  ctrl_sts_t sts_i,
  output logic      req_ready_o,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && (req_action_i == ACT_QUERY)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.last_probe) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i && (req_action_i == ACT_QUERY);
      end
      ST_PROBE: cmd_o.probe = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  cmd_o.emit = sts_i.rsp_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/gccc_dp.sv */
module gccc_dp import gccc_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  input  logic                    req_action_i,
  input  logic [ROW_W-1:0]        req_row_i,
  input  logic [ROW_W-1:0]        req_col_i,
  input  logic signed [VAL_W-1:0] req_cell_value_i,
  input  logic                    cfg_valid_i,
  input  logic [RAD_W-1:0]        cfg_clear_radius_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic                    rsp_clear_o,
  output logic                    rsp_out_of_range_o,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_sts_t               sts_o
);

  localparam int SIDE_W  = $clog2(MAP_SIDE);
  localparam int CELLS   = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int MAG_W   = (SIDE_W + 1 > ROW_W + 1) ? SIDE_W + 1 : ROW_W + 1;
  localparam int COORD_W = MAG_W + 1;

  localparam logic signed [COORD_W-1:0] SIDE_S   = COORD_W'(MAP_SIDE);
  localparam logic [ADDR_W-1:0]         SIDE_MUL = ADDR_W'(MAP_SIDE);

  logic [RAD_W-1:0] radius_q;
  logic [ROW_W-1:0] row_q, col_q;
  logic [RAD_W-1:0] k_q, k_d;
  arm_e             arm_q, arm_d;
  logic             blk_q, blk_d, oor_q, oor_d;
  logic             pend_q, pend_oor_q;
  logic             rsp_valid_q, rsp_clear_q, rsp_oor_q;

  logic signed [COORD_W-1:0] row_s, col_s, k_s, pr_s, pc_s;
  logic                      p_oor;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      ld_in_map, ld_blocked, we;
  logic [0:0]                rd_data;

  // Radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_clear_radius_i;
    end
  end

  // Load path: write straight from the accepted request.
  assign ld_in_map  = (MAG_W'(req_row_i) < MAG_W'(MAP_SIDE)) &&
                      (MAG_W'(req_col_i) < MAG_W'(MAP_SIDE));
  assign ld_blocked = (req_cell_value_i == OCC_UNKNOWN) || (req_cell_value_i == OCC_FULL);
  assign we         = req_valid_i && req_ready_i && (req_action_i == ACT_LOAD) && ld_in_map;
  assign wr_addr    = ADDR_W'(req_row_i) * SIDE_MUL + ADDR_W'(req_col_i);

  // Probe coordinate of the current arm step.
  assign row_s = COORD_W'(row_q);
  assign col_s = COORD_W'(col_q);
  assign k_s   = COORD_W'(k_q);

  always_comb begin
    pr_s = row_s;
    pc_s = col_s;
    case (arm_q)
      ARM_UP:    pr_s = row_s + k_s;
      ARM_DOWN:  pr_s = row_s - k_s;
      ARM_RIGHT: pc_s = col_s + k_s;
      ARM_LEFT:  pc_s = col_s - k_s;
      default: ;
    endcase
  end

  assign p_oor   = (pr_s < 0) || (pc_s < 0) || (pr_s >= SIDE_S) || (pc_s >= SIDE_S);
  assign rd_addr = ADDR_W'(pr_s[MAG_W-1:0]) * SIDE_MUL + ADDR_W'(pc_s[MAG_W-1:0]);

  gccc_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (ld_blocked),
    .re_i    (cmd_i.probe && !p_oor),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Step counter: four arms per offset.
  always_comb begin
    k_d   = k_q;
    arm_d = arm_q;
    if (cmd_i.start) begin
      k_d   = '0;
      arm_d = ARM_UP;
    end else if (cmd_i.probe) begin
      if (arm_q == ARM_LEFT) begin
        arm_d = ARM_UP;
        k_d   = k_q + RAD_W'(1);
      end else begin
        arm_d = arm_e'(arm_q + 2'd1);
      end
    end
  end

  assign sts_o.last_probe = (arm_q == ARM_LEFT) && (k_q == radius_q);
  assign sts_o.rsp_free   = !rsp_valid_q || rsp_ready_i;

  // Fold in the read issued last cycle.
  always_comb begin
    blk_d = blk_q;
    oor_d = oor_q;
    if (cmd_i.start) begin
      blk_d = 1'b0;
      oor_d = 1'b0;
    end else if (pend_q) begin
      blk_d = blk_q | pend_oor_q | rd_data[0];
      oor_d = oor_q | pend_oor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= req_row_i;
      col_q <= req_col_i;
    end
    k_q        <= k_d;
    arm_q      <= arm_d;
    blk_q      <= blk_d;
    oor_q      <= oor_d;
    pend_oor_q <= p_oor;
    if (cmd_i.emit) begin
      rsp_clear_q <= !blk_q;
      rsp_oor_q   <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.probe;
      if (cmd_i.emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_clear_o        = rsp_clear_q;
  assign rsp_out_of_range_o = rsp_oor_q;

endmodule

/* design/grid_cross_clearance_check.sv */
// Load request: written to the map in the cycle it is accepted, ready again next cycle.
// Query request: the single map read port walks one arm cell per cycle, four arms per
// offset from 0 to clear_radius, then a drain step, then an emit step that waits for a
// free output register; the controller is then idle and takes the next request.
// Result sits in an output register; the next request is taken while it waits.
// Reset (rst_ni low, asynchronous): radius returns to 25, controller idles, output empties.
module grid_cross_clearance_check import gccc_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gccc_req_if.sink    req_i,
  gccc_cfg_if.sink    cfg_i,
  gccc_rsp_if.source  rsp_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      req_ready;

  // Radius writes go straight into the radius register and never stall.
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  // Controller: idle, probe one arm cell per cycle, drain the last read, emit.
  gccc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .sts_i        (sts),
    .req_ready_o  (req_ready),
    .cmd_o        (cmd)
  );

  // Datapath: map memory, radius register, step counter, flag accumulators and
  // the output register. Off-map arm cells skip the read and count as blocked.
  gccc_dp #(
    .MAP_SIDE (MAP_SIDE)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (req_i.valid),
    .req_ready_i        (req_ready),
    .req_action_i       (req_i.action),
    .req_row_i          (req_i.row),
    .req_col_i          (req_i.col),
    .req_cell_value_i   (req_i.cell_value),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_clear_radius_i (cfg_i.clear_radius),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_clear_o        (rsp_o.clear),
    .rsp_out_of_range_o (rsp_o.out_of_range),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

/* design/gccc_checker.sv */
`include "grid_cross_clearance_check_assert.svh"

module gccc_checker import gccc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_action_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_clear_i,
  input logic rsp_oor_i
);

  logic req_acc;

  assign req_acc = req_valid_i && req_ready_i;

  // A load never stalls the request side.
  `GCCC_ASSERT_NXT(a_load_one_cycle, req_acc && (req_action_i == ACT_LOAD), req_ready_i)
  // A query holds off further requests while the arms are walked.
  `GCCC_ASSERT_NXT(a_query_busy, req_acc && (req_action_i == ACT_QUERY), !req_ready_i)
  // A new result only appears at the end of a walk.
  `GCCC_ASSERT_IMP(a_rsp_after_walk, $rose(rsp_valid_i), !$past(req_ready_i))
  // An off-map cell always blocks.
  `GCCC_ASSERT_IMP(a_oor_blocks, rsp_valid_i, !(rsp_clear_i && rsp_oor_i))
  // Hold a stalled result.
  `GCCC_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
                   rsp_valid_i && $stable(rsp_clear_i) && $stable(rsp_oor_i))

endmodule

bind grid_cross_clearance_check gccc_checker u_gccc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_clear_i  (rsp_o.clear),
  .rsp_oor_i    (rsp_o.out_of_range)
);
